// ===== design/prefix_expression_evaluator_unit_assert.svh =====
// Assertion macros for the prefix expression evaluator.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef PREFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`define PREFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define PEE_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prefix evaluator check failed");
// next-cycle implication
`define PEE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prefix evaluator check failed");
`else
`define PEE_ASSERT_IMPL(name, ante, cons)
`define PEE_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== design/pee_pkg.sv =====
// Shared types and constants for the prefix expression evaluator.
// No dependencies; used by every other file except the assertion macro header.
package pee_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int DCNT_W      = $clog2(VALUE_WIDTH);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [PTR_W-1:0]       ptr_t;
    typedef logic [PTR_W:0]         cnt_t;
    typedef logic [QPTR_W-1:0]      qptr_t;
    typedef logic [QPTR_W:0]        qcnt_t;
    typedef logic [DCNT_W-1:0]      dcnt_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_DIVZERO   = 2'd3
    } status_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] digit;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic   start;
        value_t dividend;
        value_t divisor;
    } div_req_t;

    typedef struct packed {
        logic   done;
        value_t quotient;
    } div_rsp_t;

endpackage

// ===== design/pee_if.sv =====
// Handshake channels of the prefix expression evaluator: symbol in, result out.
// Depends on pee_pkg.
interface pee_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, symbol, last, input ready);
    modport sink   (input valid, symbol, last, output ready);
endinterface

interface pee_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [pee_pkg::VALUE_WIDTH-1:0] value;
    logic [1:0]                         status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

// ===== design/pee_cmd_queue.sv =====
// Short command queue between the decode front and the stack engine.
// Depends on pee_pkg.
module pee_cmd_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  pee_pkg::cmd_t push_cmd,
    output logic          push_ready,
    output logic          pop_valid,
    output pee_pkg::cmd_t pop_cmd,
    input  logic          pop_ready
);

    pee_pkg::cmd_t  entry_reg [pee_pkg::QUEUE_DEPTH];
    pee_pkg::qptr_t wr_ptr_reg;
    pee_pkg::qptr_t wr_ptr_next;
    pee_pkg::qptr_t rd_ptr_reg;
    pee_pkg::qptr_t rd_ptr_next;
    pee_pkg::qcnt_t fill_reg;
    pee_pkg::qcnt_t fill_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (fill_reg != pee_pkg::qcnt_t'(pee_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == pee_pkg::qptr_t'(pee_pkg::QUEUE_DEPTH - 1))
            begin
                wr_ptr_next = '0;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + pee_pkg::qptr_t'(1);
            end
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == pee_pkg::qptr_t'(pee_pkg::QUEUE_DEPTH - 1))
            begin
                rd_ptr_next = '0;
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + pee_pkg::qptr_t'(1);
            end
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + pee_pkg::qcnt_t'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - pee_pkg::qcnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/pee_front.sv =====
// Decode front: takes symbol beats and classifies them into stack commands.
// Depends on pee_pkg and pee_sym_if.
module pee_front
(
    pee_sym_if.sink       symbols,
    output logic          push_valid,
    output pee_pkg::cmd_t push_cmd,
    input  logic          push_ready
);

    pee_pkg::op_t op;

    always_comb
    begin
        case (symbols.symbol)
            pee_pkg::CH_PLUS:  op = pee_pkg::OP_ADD;
            pee_pkg::CH_MINUS: op = pee_pkg::OP_SUB;
            pee_pkg::CH_STAR:  op = pee_pkg::OP_MUL;
            pee_pkg::CH_SLASH: op = pee_pkg::OP_DIV;
            default:
            begin
                if (symbols.symbol >= pee_pkg::CH_ZERO && symbols.symbol <= pee_pkg::CH_NINE)
                begin
                    op = pee_pkg::OP_PUSH;
                end
                else
                begin
                    op = pee_pkg::OP_NONE;
                end
            end
        endcase
    end

    assign push_cmd.op    = op;
    assign push_cmd.digit = symbols.symbol[3:0];   // '0'..'9' are 0x30..0x39
    assign push_cmd.last  = symbols.last;
    assign push_valid     = symbols.valid;
    assign symbols.ready  = push_ready;

endmodule

// ===== design/pee_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pee_pkg. Divisor must be non-zero.
module pee_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  pee_pkg::div_req_t req,
    output pee_pkg::div_rsp_t rsp
);

    logic                           busy_reg;
    logic                           busy_next;
    logic                           done_reg;
    logic                           done_next;
    pee_pkg::dcnt_t                 cnt_reg;
    pee_pkg::dcnt_t                 cnt_next;
    logic [pee_pkg::VALUE_WIDTH:0]  rem_reg;
    logic [pee_pkg::VALUE_WIDTH:0]  rem_next;
    pee_pkg::value_t                quo_reg;
    pee_pkg::value_t                quo_next;
    pee_pkg::value_t                dvs_reg;
    pee_pkg::value_t                dvs_next;
    logic                           neg_reg;
    logic                           neg_next;
    pee_pkg::value_t                mag_a;
    pee_pkg::value_t                mag_b;
    logic [pee_pkg::VALUE_WIDTH:0]  rem_shift;
    logic [pee_pkg::VALUE_WIDTH:0]  diff;

    assign mag_a = req.dividend[pee_pkg::VALUE_WIDTH-1] ? (~req.dividend + pee_pkg::value_t'(1))
                                                         : req.dividend;
    assign mag_b = req.divisor[pee_pkg::VALUE_WIDTH-1] ? (~req.divisor + pee_pkg::value_t'(1))
                                                        : req.divisor;
    assign rem_shift = {rem_reg[pee_pkg::VALUE_WIDTH-1:0], quo_reg[pee_pkg::VALUE_WIDTH-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = mag_a;
            dvs_next  = mag_b;
            neg_next  = req.dividend[pee_pkg::VALUE_WIDTH-1] ^ req.divisor[pee_pkg::VALUE_WIDTH-1];
        end
        else if (busy_reg)
        begin
            if (!diff[pee_pkg::VALUE_WIDTH])
            begin
                rem_next = diff;
                quo_next = {quo_reg[pee_pkg::VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                quo_next = {quo_reg[pee_pkg::VALUE_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + pee_pkg::dcnt_t'(1);
            if (cnt_reg == pee_pkg::dcnt_t'(pee_pkg::VALUE_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (~quo_reg + pee_pkg::value_t'(1)) : quo_reg;

endmodule

// ===== design/pee_back.sv =====
// Stack engine: operand stack memory, arithmetic, error tracking, result register.
// Depends on pee_pkg, pee_res_if, pee_div and the assertion macro header.
`include "prefix_expression_evaluator_unit_assert.svh"

module pee_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  pee_pkg::cmd_t cmd,
    output logic          cmd_ready,
    pee_res_if.source     results
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    pee_pkg::cnt_t       count_reg;
    pee_pkg::cnt_t       count_next;
    pee_pkg::status_t    error_reg;
    pee_pkg::status_t    error_next;
    pee_pkg::value_t     bottom_reg;
    pee_pkg::value_t     bottom_next;
    pee_pkg::op_t        op_reg;
    pee_pkg::op_t        op_next;
    logic                last_reg;
    logic                last_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    pee_pkg::value_t     out_value_reg;
    pee_pkg::value_t     out_value_next;
    pee_pkg::status_t    out_status_reg;
    pee_pkg::status_t    out_status_next;

    pee_pkg::value_t     stack_mem [pee_pkg::STACK_DEPTH];
    pee_pkg::value_t     rd_left_reg;
    pee_pkg::value_t     rd_right_reg;
    logic                mem_we;
    pee_pkg::ptr_t       mem_waddr;
    pee_pkg::value_t     mem_wdata;

    pee_pkg::value_t     left;
    pee_pkg::value_t     right;
    logic                underflow;
    pee_pkg::cnt_t       base;
    pee_pkg::status_t    err_pop;
    logic                emit_fire;
    logic [2*pee_pkg::VALUE_WIDTH-1:0] product;

    pee_pkg::div_req_t   div_req;
    pee_pkg::div_rsp_t   div_rsp;

    pee_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Operands as seen after the two pops; an empty slot supplies zero.
    assign left      = (count_reg >= pee_pkg::cnt_t'(1)) ? rd_left_reg : '0;
    assign right     = (count_reg >= pee_pkg::cnt_t'(2)) ? rd_right_reg : '0;
    assign underflow = (count_reg < pee_pkg::cnt_t'(2));
    assign base      = underflow ? '0 : (count_reg - pee_pkg::cnt_t'(2));
    assign err_pop   = (error_reg == pee_pkg::ST_OK && underflow) ? pee_pkg::ST_UNDERFLOW
                                                                   : error_reg;
    assign product   = left * right;
    assign emit_fire = (state_reg == S_EMIT) && (!out_valid_reg || results.ready);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        error_next       = error_reg;
        bottom_next      = bottom_reg;
        op_next          = op_reg;
        last_next        = last_reg;
        out_valid_next   = out_valid_reg && !results.ready;
        out_value_next   = out_value_reg;
        out_status_next  = out_status_reg;
        cmd_ready        = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = count_reg[pee_pkg::PTR_W-1:0];
        mem_wdata        = '0;
        div_req.start    = 1'b0;
        div_req.dividend = left;
        div_req.divisor  = right;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_ready = 1'b1;
                    op_next   = cmd.op;
                    last_next = cmd.last;
                    case (cmd.op)
                        pee_pkg::OP_PUSH:
                        begin
                            if (count_reg == pee_pkg::cnt_t'(pee_pkg::STACK_DEPTH))
                            begin
                                if (error_reg == pee_pkg::ST_OK)
                                begin
                                    error_next = pee_pkg::ST_OVERFLOW;
                                end
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_wdata  = pee_pkg::value_t'(cmd.digit);
                                count_next = count_reg + pee_pkg::cnt_t'(1);
                                if (count_reg == '0)
                                begin
                                    bottom_next = mem_wdata;
                                end
                            end
                            state_next = cmd.last ? S_EMIT : S_IDLE;
                        end
                        pee_pkg::OP_ADD, pee_pkg::OP_SUB, pee_pkg::OP_MUL, pee_pkg::OP_DIV:
                        begin
                            state_next = S_EXEC;
                        end
                        default:
                        begin
                            state_next = cmd.last ? S_EMIT : S_IDLE;
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                error_next = err_pop;
                mem_waddr  = base[pee_pkg::PTR_W-1:0];
                count_next = base + pee_pkg::cnt_t'(1);
                state_next = last_reg ? S_EMIT : S_IDLE;
                mem_we     = 1'b1;
                case (op_reg)
                    pee_pkg::OP_ADD: mem_wdata = left + right;
                    pee_pkg::OP_SUB: mem_wdata = left - right;
                    pee_pkg::OP_MUL: mem_wdata = product[pee_pkg::VALUE_WIDTH-1:0];
                    default:
                    begin
                        if (right == '0)
                        begin
                            mem_wdata = '0;
                            if (err_pop == pee_pkg::ST_OK)
                            begin
                                error_next = pee_pkg::ST_DIVZERO;
                            end
                        end
                        else
                        begin
                            mem_we        = 1'b0;
                            count_next    = base;
                            div_req.start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                endcase
                if (mem_we && base == '0)
                begin
                    bottom_next = mem_wdata;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = div_rsp.quotient;
                    count_next = count_reg + pee_pkg::cnt_t'(1);
                    if (count_reg == '0)
                    begin
                        bottom_next = mem_wdata;
                    end
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = (count_reg != '0) ? bottom_reg : '0;
                    out_status_next = error_reg;
                    count_next      = '0;
                    error_next      = pee_pkg::ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            error_reg     <= pee_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            error_reg     <= error_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bottom_reg     <= bottom_next;
        op_reg         <= op_next;
        last_reg       <= last_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    // Stack memory: one write port, two registered read ports at the top two entries.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        rd_left_reg  <= stack_mem[pee_pkg::ptr_t'(count_reg - pee_pkg::cnt_t'(1))];
        rd_right_reg <= stack_mem[pee_pkg::ptr_t'(count_reg - pee_pkg::cnt_t'(2))];
    end

    assign results.valid  = out_valid_reg;
    assign results.value  = $signed(out_value_reg);
    assign results.status = out_status_reg;

    `PEE_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= pee_pkg::cnt_t'(pee_pkg::STACK_DEPTH))
    `PEE_ASSERT_IMPL(a_div_start_in_exec, div_req.start, state_reg == S_EXEC)
    `PEE_ASSERT_NEXT(a_error_sticky, error_reg != pee_pkg::ST_OK && state_reg != S_EMIT, error_reg == $past(error_reg))
    `PEE_ASSERT_NEXT(a_emit_clears, emit_fire, count_reg == '0 && error_reg == pee_pkg::ST_OK && out_valid_reg)

endmodule

// ===== design/prefix_expression_evaluator_unit.sv =====
// Prefix expression evaluator: decode front, 2-entry command queue, stack engine.
// Digit or ignored symbol: handled as it is accepted; + - *: a stack read, then execute;
// /: as + - *, then for a non-zero divisor a wait on the bit-serial divider (one quotient bit per cycle).
// A last beat adds an emit step that loads the result register once the output is free.
// Asynchronous active-low reset empties the queue and stack and clears the error.
// Depends on pee_pkg, pee_if, pee_front, pee_cmd_queue, pee_back.
module prefix_expression_evaluator_unit
(
    input  logic      clk,
    input  logic      rst_n,
    pee_sym_if.sink   symbols,
    pee_res_if.source results
);

    logic          push_valid;
    pee_pkg::cmd_t push_cmd;
    logic          push_ready;
    logic          pop_valid;
    pee_pkg::cmd_t pop_cmd;
    logic          pop_ready;

    pee_front u_front
    (
        .symbols    (symbols),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    pee_cmd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    pee_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .cmd_ready (pop_ready),
        .results   (results)
    );

endmodule
